// ----- rtl/midi_note_pairing_quantizer_assert.svh -----
// ---------------------------------------------------------------------------
// midi_note_pairing_quantizer_assert
// Assertion macros for the MIDI note pairing quantizer.
// ---------------------------------------------------------------------------
`ifndef MIDI_NOTE_PAIRING_QUANTIZER_ASSERT_SVH
`define MIDI_NOTE_PAIRING_QUANTIZER_ASSERT_SVH

// Implication checked every clock, disabled in reset.
`define MNPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define MNPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/mnpq_pkg.sv -----
// ---------------------------------------------------------------------------
// mnpq_pkg
// Shared types and constants of the MIDI note pairing quantizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mnpq_pkg;

   localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
   localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
   localparam logic [1:0] CMD_END      = 2'd2;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   localparam logic [2:0] ST_HELD      = 3'd0;
   localparam logic [2:0] ST_OVERLAP   = 3'd1;
   localparam logic [2:0] ST_DONE      = 3'd2;
   localparam logic [2:0] ST_UNMATCHED = 3'd3;
   localparam logic [2:0] ST_END       = 3'd4;

   localparam logic [2:0] Q_NONE    = 3'd0;
   localparam logic [2:0] Q_MAJOR   = 3'd1;
   localparam logic [2:0] Q_MINOR   = 3'd2;
   localparam logic [2:0] Q_POWER   = 3'd3;
   localparam logic [2:0] Q_SUS4    = 3'd4;
   localparam logic [2:0] Q_SUS2    = 3'd5;
   localparam logic [2:0] Q_CLUSTER = 3'd6;

   localparam int DIV_W = 35;   // dividend width: 8*t + tpq fits in 36, quotient in 35
   localparam int DEN_W = 16;   // 2*tpq

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_READ,
      S_LOOK,
      S_DIV_START,
      S_DIV_WAIT,
      S_DIV_DUR,
      S_DUR_WAIT,
      S_FINISH,
      S_OUT
   } state_type;

   // chord pitch-class check: rotate mask so the root sits at bit 0
   function automatic logic [11:0] rot_mask(input logic [11:0] m, input logic [3:0] r);
      logic [23:0] d;
      d = {m, m} >> r;
      return d[11:0];
   endfunction

   // note number to pitch class by conditional subtraction of 96, 48, 24, 12
   function automatic logic [3:0] pitch_class(input logic [6:0] n);
      logic [6:0] r;
      r = n;
      if (r >= 7'd96) r = r - 7'd96;
      if (r >= 7'd48) r = r - 7'd48;
      if (r >= 7'd24) r = r - 7'd24;
      if (r >= 7'd12) r = r - 7'd12;
      return r[3:0];
   endfunction

endpackage

// ----- rtl/mnpq_divider.sv -----
// ---------------------------------------------------------------------------
// mnpq_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mnpq_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mnpq_pkg::DIV_W:0]      dividend,
   input  logic [mnpq_pkg::DEN_W-1:0]    divisor,
   output logic                          busy,
   output logic                          done,
   output logic [mnpq_pkg::DIV_W-1:0]    quotient
);
   import mnpq_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 2);

   logic [DIV_W:0]       num_ff, num_in;
   logic [DEN_W:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W+1:0]     diff;

   always_comb begin
      trial   = {rem_ff[DEN_W-1:0], num_ff[DIV_W]};
      diff    = {1'b0, trial} - {2'b0, divisor};
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIV_W + 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W:0];
         end else begin
            rem_in = trial;
         end
         num_in = {num_ff[DIV_W-1:0], ~diff[DEN_W+1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = num_ff[DIV_W-1:0];

endmodule

// ----- rtl/midi_note_pairing_quantizer.sv -----
// ---------------------------------------------------------------------------
// midi_note_pairing_quantizer
// Pairs MIDI note-on/off requests and quantizes them to sixteenth notes.
// ---------------------------------------------------------------------------
// One request in, one response out (command 3 gives none). A note-on, an end
// or an unmatched off needs no division. For a completed note the start, and
// the duration when its off time is after its start, are each divided by
// 2*ticks_per_quarter in a bit-serial divider, one quotient bit a cycle.
// After reset the held-note table (CHANNELS*NOTES entries, each with its valid
// bit) is swept clear, one entry a cycle, before the first request is taken.
// The response sits in an output register; the next request is taken once
// it has been delivered. Rounding is half up; a zero tick division is 1.
`timescale 1ns / 1ps
`include "midi_note_pairing_quantizer_assert.svh"

module midi_note_pairing_quantizer #(
   parameter int CHANNELS = 16,
   parameter int NOTES    = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [14:0]  csr_wdata,          // ticks_per_quarter
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,          // command[1:0], channel[5:2], note_number[12:6],
                                            // velocity[19:13], time_ticks[51:20], zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata           // status[2:0], done_note[9:3], done_velocity[16:10],
                                            // start_sixteenths[51:17], duration[86:52],
                                            // length[122:87], chord_root[126:123],
                                            // chord_quality[129:127], still_held[130],
                                            // any_done[131], zero
);
   import mnpq_pkg::*;

   localparam int DEPTH = CHANNELS * NOTES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HW    = $clog2(DEPTH + 1);

   // table: valid bit, start tick, velocity
   logic [39:0] table_mem [DEPTH];
   logic [39:0] rd_ff;
   logic        we;
   logic [AW-1:0] waddr;
   logic [39:0] wdata;

   state_type   state_ff, state_in;
   logic [14:0] tpq_ff;
   logic [1:0]  cmd_ff;
   logic [6:0]  note_ff, vel_ff;
   logic [31:0] t_ff;
   logic [AW-1:0] idx_ff, clr_ff, clr_in;
   logic        inr_ff;
   logic [HW-1:0] held_ff, held_in;
   logic [11:0] mask_ff, mask_in;
   logic        capt_ff, capt_in, compl_ff, compl_in;
   logic [35:0] plen_ff, plen_in;
   logic [34:0] s16_ff, s16_in;
   logic [135:0] out_ff, out_in;
   logic        ov_ff, ov_in;

   logic         div_start;
   logic         div_busy;
   logic         div_done;
   logic [DIV_W:0] dnum;
   logic [15:0]  dden;
   logic [34:0]  dq;

   logic [14:0] tpq_eff;
   logic [41:0] t1000;
   logic        early;
   logic [31:0] dur_t;
   logic        idx_ok;
   logic [11:0] rm;
   logic [3:0]  root;
   logic [2:0]  qual;
   logic [34:0] d16;
   logic [35:0] endsum;

   assign tpq_eff = (tpq_ff == 15'd0) ? 15'd1 : tpq_ff;
   // 1000*t = 1024*t - 32*t + 8*t
   assign t1000   = {t_ff, 10'd0} - {5'd0, t_ff, 5'd0} + {7'd0, t_ff, 3'd0};
   assign early   = t1000 <= {27'd0, tpq_eff};
   assign dur_t   = t_ff - rd_ff[38:7];
   assign idx_ok  = ({28'd0, req_tdata[5:2]} < 32'(CHANNELS))
                    && ({25'd0, req_tdata[12:6]} < 32'(NOTES));

   always_comb begin
      root = 4'd0;
      for (int i = 11; i >= 0; i--) begin
         if (mask_ff[i]) begin
            root = 4'(i);
         end
      end
      rm = rot_mask(mask_ff, root);
      if (mask_ff == 12'd0)            qual = Q_NONE;
      else if (rm[4] && rm[7])         qual = Q_MAJOR;
      else if (rm[3] && rm[7])         qual = Q_MINOR;
      else if (rm[7])                  qual = Q_POWER;
      else if (rm[5])                  qual = Q_SUS4;
      else if (rm[2])                  qual = Q_SUS2;
      else                             qual = Q_CLUSTER;
   end

   assign d16    = (dq == 35'd0) ? 35'd1 : dq;
   assign endsum = {1'b0, s16_ff} + {1'b0, d16};

   mnpq_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dnum),
      .divisor(dden), .busy(div_busy), .done(div_done), .quotient(dq));

   assign dden = {tpq_eff, 1'b0};

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      held_in  = held_ff;
      mask_in  = mask_ff;
      capt_in  = capt_ff;
      compl_in = compl_ff;
      plen_in  = plen_ff;
      s16_in   = s16_ff;
      out_in   = out_ff;
      ov_in    = ov_ff;
      we       = 1'b0;
      waddr    = idx_ff;
      wdata    = '0;
      div_start = 1'b0;
      dnum     = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && !ov_ff) state_in = S_READ;
         end
         S_READ: state_in = S_LOOK;
         S_LOOK: begin
            out_in = '0;
            out_in[122:87] = plen_ff;
            if (cmd_ff == CMD_UNUSED) begin
               state_in = S_IDLE;
            end else if (cmd_ff == CMD_NOTE_ON && vel_ff != 7'd0) begin
               out_in[2:0] = ST_HELD;
               if (inr_ff) begin
                  we    = 1'b1;
                  wdata = {1'b1, t_ff, vel_ff};
                  if (rd_ff[39]) out_in[2:0] = ST_OVERLAP;
                  else held_in = held_ff + 1'b1;
               end
               if (!capt_ff && early) mask_in = mask_ff | (12'd1 << pitch_class(note_ff));
               state_in = S_OUT;
            end else if (cmd_ff != CMD_END) begin
               if (!inr_ff || !rd_ff[39]) begin
                  out_in[2:0] = ST_UNMATCHED;
                  state_in = S_OUT;
               end else begin
                  div_start = 1'b1;
                  dnum = {1'b0, rd_ff[38:7], 3'd0} + {21'd0, tpq_eff};
                  state_in = S_DIV_WAIT;
               end
            end else begin
               out_in[2:0]     = ST_END;
               out_in[126:123] = root;
               out_in[129:127] = qual;
               out_in[130]     = held_ff != '0;
               out_in[131]     = compl_ff;
               state_in = S_OUT;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               s16_in = dq;
               if (t_ff > rd_ff[38:7]) begin
                  div_start = 1'b1;
                  dnum = {1'b0, dur_t, 3'd0} + {21'd0, tpq_eff};
                  state_in = S_DUR_WAIT;
               end else begin
                  state_in = S_DIV_DUR;
               end
            end
         end
         S_DIV_DUR, S_DUR_WAIT, S_FINISH: begin
            if (state_ff == S_DIV_DUR || div_done) begin
               we    = 1'b1;
               wdata = '0;
               held_in  = held_ff - 1'b1;
               compl_in = 1'b1;
               if (!capt_ff && !early) capt_in = 1'b1;
               out_in[2:0]   = ST_DONE;
               out_in[9:3]   = note_ff;
               out_in[16:10] = rd_ff[6:0];
               out_in[51:17] = s16_ff;
               out_in[86:52] = (state_ff == S_DIV_DUR) ? 35'd1 : d16;
               if (((state_ff == S_DIV_DUR) ? {1'b0, s16_ff} + 36'd1 : endsum) > plen_ff) begin
                  plen_in = (state_ff == S_DIV_DUR) ? {1'b0, s16_ff} + 36'd1 : endsum;
               end
               out_in[122:87] = plen_in;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            ov_in    = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         tpq_ff   <= 15'd480;
         held_ff  <= '0;
         mask_ff  <= '0;
         capt_ff  <= 1'b0;
         compl_ff <= 1'b0;
         plen_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_we) tpq_ff <= csr_wdata;
         held_ff  <= held_in;
         mask_ff  <= mask_in;
         capt_ff  <= capt_in;
         compl_ff <= compl_in;
         plen_ff  <= plen_in;
         ov_ff    <= ov_in;
      end
      s16_ff <= s16_in;
      out_ff <= out_in;
      if (req_tready && req_tvalid) begin
         cmd_ff  <= req_tdata[1:0];
         note_ff <= req_tdata[12:6];
         vel_ff  <= req_tdata[19:13];
         t_ff    <= req_tdata[51:20];
         inr_ff  <= idx_ok;
         idx_ff  <= idx_ok ? AW'(({28'd0, req_tdata[5:2]} * 32'(NOTES))
                               + {25'd0, req_tdata[12:6]}) : '0;
      end
   end

   // table RAM: one write port, registered read
   always_ff @(posedge clock) begin
      if (we) table_mem[waddr] <= wdata;
      rd_ff <= table_mem[idx_ff];
   end

   assign req_tready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   `MNPQ_ASSERT_IMP(a_no_take_while_full, clock, reset, ov_ff, !req_tready)
   `MNPQ_ASSERT_NEXT(a_div_start_busy, clock, reset, div_start, div_busy)
   `MNPQ_ASSERT_IMP(a_clear_no_req, clock, reset, state_ff == S_CLEAR, !req_tready)

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// MIDI note pairing quantizer testbench
// Drives note-on/off/end requests through the stream port and keeps its own
// model of the held-note table, first chord and phrase length. Each response
// is checked field by field against the oldest predicted one. The run covers
// several tick-per-quarter settings and sender/receiver idling mixes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import mnpq_pkg::*;

   localparam int          TABLE_DEPTH  = 16 * 128;
   localparam int          ITEMS_TOTAL  = 1550;
   localparam int          PHASES       = 5;
   localparam int          SETTLE       = 200;   // > one full two-division request
   localparam int          HOLD_OFF_CYCLES = 600;
   localparam longint      LIMIT_CYCLES = 1_500_000;

   typedef struct {
      logic [1:0]  command;
      logic [3:0]  channel;
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [31:0] ticks;
   } req_item_type;

   typedef struct {
      logic [2:0]  status;
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [34:0] start16;
      logic [34:0] dur16;
      logic [35:0] length16;
      logic [3:0]  root;
      logic [2:0]  quality;
      logic        still_held;
      logic        any_done;
   } rsp_item_type;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [14:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;

   midi_note_pairing_quantizer dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // shadow of the block state
   logic [14:0] tpq_reg = 15'd480;
   bit          note_held [TABLE_DEPTH];
   logic [31:0] note_start [TABLE_DEPTH];
   logic [6:0]  note_vel [TABLE_DEPTH];
   int          held_total = 0;
   logic [11:0] chord_mask = '0;
   bit          chord_closed = 0;
   logic [35:0] phrase_len = '0;
   bit          any_completed = 0;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];

   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_off_go;
   logic        hold_off;
   int          errors = 0;
   longint      cycle_count = 0;
   int          n_done = 0, n_end = 0, n_overlap = 0, n_unmatched = 0, n_held = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // round(4*t/tpq), halves up
   function automatic longint unsigned to_16ths(longint unsigned t, longint unsigned q);
      return (8 * t + q) / (2 * q);
   endfunction

   function automatic void add_req(input req_item_type r);
      pending_reqs = {pending_reqs, r};
   endfunction

   // update the shadow state for one accepted request; queue its response
   task automatic predict_request(input req_item_type r);
      rsp_item_type    o;
      int              key;
      longint unsigned q, s16, d16, st;
      logic [11:0]     rot;
      int              root;
      o = '{default: '0};
      key = int'({r.channel, r.note});
      q = (tpq_reg == 0) ? 1 : tpq_reg;
      if (r.command == CMD_UNUSED) return;
      if (r.command == CMD_NOTE_ON && r.velocity != 0) begin
         if (note_held[key]) o.status = ST_OVERLAP;
         else begin
            o.status = ST_HELD;
            note_held[key] = 1;
            held_total++;
         end
         note_start[key] = r.ticks;
         note_vel[key]   = r.velocity;
         if (!chord_closed && 1000 * longint'(r.ticks) <= q)
            chord_mask[r.note % 12] = 1'b1;
      end else if (r.command != CMD_END) begin
         // note-off, or note-on with zero velocity
         if (!note_held[key]) o.status = ST_UNMATCHED;
         else begin
            st  = note_start[key];
            s16 = to_16ths(st, q);
            d16 = 1;
            if (r.ticks > st) begin
               d16 = to_16ths(r.ticks - st, q);
               if (d16 < 1) d16 = 1;
            end
            if (s16 + d16 > phrase_len) phrase_len = 36'(s16 + d16);
            note_held[key] = 0;
            held_total--;
            any_completed = 1;
            if (!chord_closed && 1000 * longint'(r.ticks) > q) chord_closed = 1;
            o.status   = ST_DONE;
            o.note     = r.note;
            o.velocity = note_vel[key];
            o.start16  = 35'(s16);
            o.dur16    = 35'(d16);
         end
      end else begin
         o.status = ST_END;
         if (chord_mask != 0) begin
            root = 0;
            while (!chord_mask[root]) root++;
            rot = 12'({chord_mask, chord_mask} >> root);
            if (rot[4] && rot[7])      o.quality = Q_MAJOR;
            else if (rot[3] && rot[7]) o.quality = Q_MINOR;
            else if (rot[7])           o.quality = Q_POWER;
            else if (rot[5])           o.quality = Q_SUS4;
            else if (rot[2])           o.quality = Q_SUS2;
            else                       o.quality = Q_CLUSTER;
            o.root = 4'(root);
         end
         o.still_held = (held_total != 0);
         o.any_done   = any_completed;
      end
      o.length16 = phrase_len;
      expected_rsps = {expected_rsps, o};
   endtask

   // ---------------------------------------------------------------------
   // Request driver: predicts on acceptance, then offers the next request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      req_item_type nxt;
      logic         offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_request(req_item_type'{req_tdata[1:0], req_tdata[5:2], req_tdata[12:6],
                                           req_tdata[19:13], req_tdata[51:20]});
            offer = 1'b0;
         end
         if (!offer && pending_reqs.size() != 0
             && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_tdata <= {4'b0, nxt.ticks, nxt.velocity, nxt.note, nxt.channel, nxt.command};
            offer = 1'b1;
         end
         req_tvalid <= offer;
      end
   end

   task automatic check_field(input string name, input longint unsigned exp_v,
                              input longint unsigned act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   // long receiver hold-off, counted here once the main sequence asks for it
   initial begin
      hold_off = 1'b0;
      wait (hold_off_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Response monitor: random back-pressure plus one long hold-off
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type e;
      if (reset) rsp_tready <= 1'b0;
      else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: response with none expected, actual %h", $time, rsp_tdata);
            end else begin
               e = expected_rsps.pop_front();
               check_field("status",     e.status,     rsp_tdata[2:0]);
               check_field("done_note",  e.note,       rsp_tdata[9:3]);
               check_field("done_vel",   e.velocity,   rsp_tdata[16:10]);
               check_field("start16",    e.start16,    rsp_tdata[51:17]);
               check_field("duration16", e.dur16,      rsp_tdata[86:52]);
               check_field("length16",   e.length16,   rsp_tdata[122:87]);
               check_field("chord_root", e.root,       rsp_tdata[126:123]);
               check_field("quality",    e.quality,    rsp_tdata[129:127]);
               check_field("still_held", e.still_held, rsp_tdata[130]);
               check_field("any_done",   e.any_done,   rsp_tdata[131]);
               case (e.status)
                  ST_HELD:    n_held++;
                  ST_OVERLAP: n_overlap++;
                  ST_DONE:    n_done++;
                  ST_END:     n_end++;
                  default:    n_unmatched++;
               endcase
            end
         end
         if (hold_off === 1'b1) rsp_tready <= 1'b0;
         else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("midi_note_pairing_quantizer test failed");
         $finish;
      end
   end

   function automatic req_item_type mk(logic [1:0] c, logic [3:0] ch, logic [6:0] n,
                                       logic [6:0] v, logic [31:0] t);
      req_item_type r;
      r = '{c, ch, n, v, t};
      return r;
   endfunction

   task automatic write_tpq(input logic [14:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      tpq_reg    = v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);   // a trailing unused command may still be in flight
   endtask

   // well-formed note runs with random content, plus noise
   task automatic gen_random(input int count);
      req_item_type open_keys[$];
      req_item_type r;
      logic [31:0]  now;
      int           n, pick, sel;
      now = 0;
      n = 0;
      while (n < count) begin
         sel = $urandom_range(99);
         if (sel < 5) now = $urandom;
         else if (sel < 12) now = $urandom_range(0, 40);
         else now = now + $urandom_range(0, 2000);
         pick = $urandom_range(99);
         if (open_keys.size() > 20) pick = 50;
         if (pick < 40) begin
            if (open_keys.size() != 0 && $urandom_range(9) == 0)
               r = open_keys[$urandom_range(open_keys.size() - 1)];
            else if ($urandom_range(3) == 0)
               r = mk(CMD_NOTE_ON, 4'($urandom), 7'($urandom), 0, 0);
            else
               r = mk(CMD_NOTE_ON, 4'($urandom_range(0, 1)), 7'($urandom_range(48, 72)), 0, 0);
            r.command  = CMD_NOTE_ON;
            r.velocity = 7'($urandom_range(1, 127));
            r.ticks    = now;
            open_keys = {open_keys, r};
         end else if (pick < 80 && open_keys.size() != 0) begin
            sel = $urandom_range(open_keys.size() - 1);
            r = open_keys[sel];
            open_keys.delete(sel);
            r.ticks = now;
            if ($urandom_range(4) == 0) begin
               r.command  = CMD_NOTE_ON;
               r.velocity = 0;
            end else begin
               r.command  = CMD_NOTE_OFF;
               r.velocity = 7'($urandom);
            end
         end else if (pick < 88)
            r = mk(CMD_NOTE_OFF, 4'($urandom), 7'($urandom), 7'($urandom), now);
         else if (pick < 93)
            r = mk(CMD_END, 4'($urandom), 7'($urandom), 7'($urandom), $urandom);
         else
            r = mk(2'($urandom), 4'($urandom), 7'($urandom), 7'($urandom), $urandom);
         add_req(r);
         n++;
      end
   endtask

   initial begin
      logic [14:0] tpq_set [PHASES];
      int          per_phase;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_go = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      tpq_set = '{15'd480, 15'd32767, 15'd1, 15'd0, 15'd0};
      tpq_set[4] = 15'($urandom_range(2, 32766));

      // directed: chord at zero, extremes, overlap, off-before-on, end, unused
      write_tpq(tpq_set[0]);
      add_req(mk(CMD_END,      0,  0,   0,  0));
      add_req(mk(CMD_NOTE_ON,  0,  60, 100, 0));
      add_req(mk(CMD_NOTE_ON,  0,  64, 1,   0));
      add_req(mk(CMD_NOTE_ON,  15, 127, 127, 0));
      add_req(mk(CMD_NOTE_ON,  0,  67, 90,  0));
      add_req(mk(CMD_NOTE_ON,  0,  60, 77,  0));          // overlap
      add_req(mk(CMD_END,      0,  0,   0,  0));
      add_req(mk(CMD_NOTE_OFF, 0,  64, 127, 0));          // off at start
      add_req(mk(CMD_NOTE_OFF, 3,  10, 0,   100));        // unmatched
      add_req(mk(CMD_UNUSED,   15, 127, 127, 32'hFFFF_FFFF));
      add_req(mk(CMD_NOTE_ON,  0,  60, 0,   240));        // zero-velocity off
      add_req(mk(CMD_NOTE_ON,  0,  62, 50,  0));          // chord closed now
      add_req(mk(CMD_NOTE_ON,  9,  0,  127, 32'hFFFF_FFFF));
      add_req(mk(CMD_NOTE_OFF, 9,  0,  0,   32'hFFFF_FFFF));
      add_req(mk(CMD_NOTE_OFF, 15, 127, 0,  32'hFFFF_FFFF));
      add_req(mk(CMD_NOTE_ON,  5,  30, 3,   32'hFFFF_FFF0));
      add_req(mk(CMD_NOTE_OFF, 5,  30, 0,   16));         // wraps: off before on
      add_req(mk(CMD_END,      0,  0,   0,  0));
      drain();

      per_phase = (ITEMS_TOTAL - 20) / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         write_tpq(tpq_set[(p + 1) % PHASES]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         if (p == 0) hold_off_go = 1;   // fill the block and stall its input
         gen_random(per_phase);
         drain();
      end

      $display("covered %0d held, %0d overlaps, %0d completed, %0d unmatched, %0d end reports",
               n_held, n_overlap, n_done, n_unmatched, n_end);
      $display("tick divisions 0, 1, 480, 32767 and %0d; %0d mismatches", tpq_set[4], errors);
      if (errors == 0)
         $display("midi_note_pairing_quantizer test passed");
      else
         $display("midi_note_pairing_quantizer test failed");
      $finish;
   end

endmodule
